FILE: rtl/bsl_pkg.sv
// Shared types, constants and tables for the bounded sigmoid / logit unit.
package bsl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int A_W       = FRAC_BITS + 6;   // |y| after clamp to 50.0
    localparam int Z_W       = 39;              // log2(e) scaled |y|, 7 int + 32 frac
    localparam int K_W       = 7;

    localparam logic [1:0] KIND_LOGIT   = 2'd0;
    localparam logic [1:0] KIND_SIGMOID = 2'd1;
    localparam logic [1:0] KIND_DERIV   = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 1'd1;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;

    localparam logic signed [VAL_W-1:0] LIM_POS = VAL_W'(50 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic [VAL_W-1:0] RANGE_MAX_RST  = VAL_W'(1 << FRAC_BITS);
    localparam logic [63:0] LG_RND              = 64'd1 << (57 - FRAC_BITS);
    localparam int LG_SHIFT                     = 58 - FRAC_BITS;

    // pipeline stage map
    localparam int LOG_STEPS    = 32;
    localparam int TAY_TERMS    = 16;
    localparam int TAY_DEPTH    = 3;
    localparam int SDIV_STEPS   = 31;
    localparam int DDIV_STEPS   = 32;
    localparam int ST_PREP      = 1;
    localparam int ST_NORM      = 2;
    localparam int ST_G         = 3;
    localparam int ST_LOG_END   = ST_NORM + LOG_STEPS;
    localparam int ST_LG_DIFF   = ST_LOG_END + 1;
    localparam int ST_LG_MUL    = ST_LG_DIFF + 1;
    localparam int ST_LG_RES    = ST_LG_MUL + 1;
    localparam int ST_TAY_END   = ST_G + TAY_TERMS * TAY_DEPTH;
    localparam int ST_SDIV_INIT = ST_TAY_END + 1;
    localparam int ST_SDIV_END  = ST_SDIV_INIT + SDIV_STEPS;
    localparam int ST_S_ADJ     = ST_SDIV_END + 1;
    localparam int ST_S_MUL     = ST_S_ADJ + 1;
    localparam int ST_S_RES     = ST_S_MUL + 1;
    localparam int ST_DDIV_END  = ST_G + DDIV_STEPS;
    localparam int ST_DRV_RES   = ST_DDIV_END + 1;
    localparam int ST_LAST      = ST_S_RES;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       lgt_err;
        logic       lgt_lo;
        logic       lgt_hi;
        logic       drv_err;
        logic       drv_neg;
        logic       sig_neg;
    } ctl_t;

    typedef struct packed {
        logic [31:0] m;
        logic [31:0] frac;
        logic [4:0]  ip;
    } lg_t;

    typedef struct packed {
        logic [32:0]        term;
        logic [31:0]        g;
        logic signed [33:0] sum;
        logic [K_W-1:0]     k;
        logic [31:0]        t;
        logic [31:0]        q0;
    } tay_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [33:0] dvs;
        logic [31:0] low;
        logic [31:0] q;
    } dv_t;

    // floor(2^35 / n)
    function automatic logic [35:0] tay_recip(input logic [4:0] n);
        logic [35:0] r;
        case (n)
            5'd1:    r = 36'd34359738368;
            5'd2:    r = 36'd17179869184;
            5'd3:    r = 36'd11453246122;
            5'd4:    r = 36'd8589934592;
            5'd5:    r = 36'd6871947673;
            5'd6:    r = 36'd5726623061;
            5'd7:    r = 36'd4908534052;
            5'd8:    r = 36'd4294967296;
            5'd9:    r = 36'd3817748707;
            5'd10:   r = 36'd3435973836;
            5'd11:   r = 36'd3123612578;
            5'd12:   r = 36'd2863311530;
            5'd13:   r = 36'd2643056797;
            5'd14:   r = 36'd2454267026;
            5'd15:   r = 36'd2290649224;
            5'd16:   r = 36'd2147483648;
            default: r = 36'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) p = 5'(i);
        end
        return p;
    endfunction

endpackage

FILE: rtl/bsl_if.sv
// Valid/ready channel interfaces: operand words, result words, config writes.
interface bsl_in_if import bsl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] in_value;
    modport source (output valid, kind, in_value, input ready);
    modport sink (input valid, kind, in_value, output ready);
endinterface

interface bsl_out_if import bsl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_value;
    logic                    range_error;
    modport source (output valid, out_value, range_error, input ready);
    modport sink (input valid, out_value, range_error, output ready);
endinterface

interface bsl_cfg_if import bsl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/bsl_log_cell.sv
// One squaring step of the log2 fraction: yields one fraction bit per cycle while en is high.
module bsl_log_cell import bsl_pkg::*; (
    input  logic clk,
    input  logic en,
    input  lg_t  d_in,
    output lg_t  d_out
);

    logic [63:0] sq;
    logic [32:0] ms;
    lg_t         d_next;
    lg_t         d_reg;

    always_comb
    begin
        sq          = d_in.m * d_in.m;
        ms          = sq[63:31];
        d_next.ip   = d_in.ip;
        d_next.frac = {d_in.frac[30:0], ms[32]};
        d_next.m    = ms[32] ? ms[32:1] : ms[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/bsl_tay_cell.sv
// One Taylor term of e^-g: term = (term*g >> 32) / n, added with alternating sign.
module bsl_tay_cell import bsl_pkg::*; (
    input  logic       clk,
    input  logic       en,
    input  logic [4:0] n,
    input  tay_t       d_in,
    output tay_t       d_out
);

    logic [64:0] p1;
    logic [67:0] p2;
    logic [36:0] qn;
    logic [36:0] rm;
    logic [31:0] q;
    tay_t        s1_next;
    tay_t        s1_reg;
    tay_t        s2_next;
    tay_t        s2_reg;
    tay_t        s3_next;
    tay_t        s3_reg;

    always_comb
    begin
        p1        = d_in.term * d_in.g;
        s1_next   = d_in;
        s1_next.t = p1[63:32];

        // reciprocal estimate, low by at most one
        p2         = s1_reg.t * tay_recip(n);
        s2_next    = s1_reg;
        s2_next.q0 = p2[66:35];

        qn      = s2_reg.q0 * n;
        rm      = {5'd0, s2_reg.t} - qn;
        q       = s2_reg.q0 + 32'(rm >= 37'(n));
        s3_next = s2_reg;
        s3_next.term = {1'b0, q};
        if (n[0])
            s3_next.sum = s2_reg.sum - $signed({2'b00, q});
        else
            s3_next.sum = s2_reg.sum + $signed({2'b00, q});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign d_out = s3_reg;

endmodule

FILE: rtl/bsl_div_cell.sv
// One restoring long-division step: one quotient bit per cycle while en is high.
module bsl_div_cell import bsl_pkg::*; (
    input  logic clk,
    input  logic en,
    input  dv_t  d_in,
    output dv_t  d_out
);

    logic [34:0] rem2;
    logic [34:0] diff;
    logic        ge;
    dv_t         d_next;
    dv_t         d_reg;

    always_comb
    begin
        rem2         = {d_in.rem, d_in.low[31]};
        diff         = rem2 - {1'b0, d_in.dvs};
        ge           = rem2 >= {1'b0, d_in.dvs};
        d_next.dvs   = d_in.dvs;
        d_next.rem   = ge ? diff[33:0] : rem2[33:0];
        d_next.low   = {d_in.low[30:0], 1'b0};
        d_next.q     = {d_in.q[30:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/bounded_sigmoid_logit_unit_top.sv
// Top level of the bounded sigmoid / logit unit: operand pipeline and result register.
// The unit takes one operand word per cycle and gives one result word per operand, in
// order, once it has passed the 86 pipeline stages and then the output register.
// Logit runs two rows of 32 squaring cells (log2 of x-min and of max-x); sigmoid runs a
// row of 16 Taylor cells (3 stages each) for e^-|y| and a row of 31 division cells for
// 1/(1+e^-|y|); derivative runs one 32x32 product and a row of 32 division cells. All
// three paths run side by side and every word walks through all of them; the kind field
// picks the answer at the end. When the result word is not taken the whole pipeline
// holds, and ready falls with it. The user must write range_min / range_max (config
// channel, always ready) only while the unit is empty, unenforced; rows read them live.
module bounded_sigmoid_logit_unit_top import bsl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bsl_in_if.sink    item,
    bsl_out_if.source result,
    bsl_cfg_if.sink   cfg
);

    // global advance: the output register is free or is being emptied
    logic adv;

    logic signed [VAL_W-1:0] range_min_reg;
    logic signed [VAL_W-1:0] range_max_reg;

    ctl_t ctl_in;
    ctl_t ctl_reg [ST_PREP:ST_LAST];

    logic signed [32:0] w33;
    logic [31:0]        w32;
    logic [31:0]        wmag;

    // stage 1
    logic signed [32:0]      x33;
    logic signed [32:0]      num33;
    logic signed [32:0]      den33;
    logic [32:0]             nabs;
    logic [32:0]             dabs;
    logic signed [VAL_W-1:0] yc;
    logic [VAL_W-1:0]        yabs;
    logic [31:0]             nm_reg;
    logic [31:0]             dm_reg;
    logic [A_W-1:0]          a_reg;

    // stage 2
    logic [4:0]        pn;
    logic [4:0]        pd;
    lg_t               lgn0_reg;
    lg_t               lgd0_reg;
    logic [63:0]       dprod_reg;
    logic [A_W+32:0]   za;
    logic [K_W-1:0]    k2_reg;
    logic [31:0]       f_reg;

    // stage 3
    logic [63:0]       gp;
    logic [31:0]       g_reg;
    logic [K_W-1:0]    k3_reg;
    logic [63:0]       dsum;
    dv_t               ddv0_reg;
    logic              drv_big_reg [ST_G:ST_DDIV_END];

    // rows of cells
    lg_t  lgn_w [0:LOG_STEPS];
    lg_t  lgd_w [0:LOG_STEPS];
    tay_t tay_w [0:TAY_TERMS];
    dv_t  sdv_w [0:SDIV_STEPS];
    dv_t  ddv_w [0:DDIV_STEPS];

    // logit tail
    logic signed [37:0]      ldiff;
    logic [37:0]             lmag;
    logic [30:0]             lmag_reg;
    logic                    lneg_reg;
    logic [62:0]             lt_reg;
    logic                    lneg2_reg;
    logic [63:0]             lrs;
    logic [31:0]             lr;
    logic signed [VAL_W-1:0] lgt_val_reg [ST_LG_RES:ST_LAST];

    // sigmoid tail
    logic [32:0]             sum_u;
    logic [32:0]             ex;
    logic [33:0]             sden;
    logic [32:0]             shd;
    dv_t                     sdv0_reg;
    logic [30:0]             sq;
    logic [30:0]             sadj_reg;
    logic [61:0]             sprod_reg;
    logic [62:0]             sdmp;
    logic signed [35:0]      sres;
    logic signed [VAL_W-1:0] sig_val_reg;

    // derivative tail
    logic [31:0]             dq;
    logic                    dbig;
    logic signed [VAL_W-1:0] drv_val;
    logic signed [VAL_W-1:0] drv_val_reg [ST_DRV_RES:ST_LAST];

    // output
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    range_error_reg;
    logic signed [VAL_W-1:0] out_value_next;
    logic                    range_error_next;
    ctl_t                    ce;

    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;
    assign cfg.ready  = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.out_value   = out_value_reg;
    assign result.range_error = range_error_reg;

    // live range width; steady while words are in flight only if config writes wait for an empty unit
    always_comb
    begin
        w33  = {range_max_reg[31], range_max_reg} - {range_min_reg[31], range_min_reg};
        w32  = w33[31:0];
        wmag = w33[32] ? 32'(-w33) : w33[31:0];
    end

    // ---------------- stage 1: differences, flags, clamp ----------------
    always_comb
    begin
        x33   = {item.in_value[31], item.in_value};
        num33 = x33 - {range_min_reg[31], range_min_reg};
        den33 = {range_max_reg[31], range_max_reg} - x33;
        nabs  = num33[32] ? 33'(-num33) : 33'(num33);
        dabs  = den33[32] ? 33'(-den33) : 33'(den33);

        if (item.in_value > LIM_POS)
            yc = LIM_POS;
        else if (item.in_value < LIM_NEG)
            yc = LIM_NEG;
        else
            yc = item.in_value;
        yabs = yc[31] ? VAL_W'(-yc) : VAL_W'(yc);

        ctl_in.valid   = item.valid;
        ctl_in.kind    = item.kind;
        ctl_in.lgt_err = num33[32] || den33[32];
        ctl_in.lgt_lo  = num33 == '0;
        ctl_in.lgt_hi  = den33 == '0;
        ctl_in.drv_err = w33[32] || (w33 == '0);
        ctl_in.drv_neg = num33[32] != den33[32];
        ctl_in.sig_neg = item.in_value[31];
    end

    // ---------------- stage 2 / 3 heads ----------------
    always_comb
    begin
        pn = msb_pos(nm_reg);
        pd = msb_pos(dm_reg);
        za = a_reg * LOG2E_Q32;
        gp = f_reg * LN2_Q32;
        // rounding half of the width
        dsum = dprod_reg + {33'd0, w32[31:1]};
    end

    // ---------------- cell rows ----------------
    assign lgn_w[0] = lgn0_reg;
    assign lgd_w[0] = lgd0_reg;

    always_comb
    begin
        tay_w[0].term = 33'h1_0000_0000;
        tay_w[0].g    = g_reg;
        tay_w[0].sum  = 34'sh1_0000_0000;
        tay_w[0].k    = k3_reg;
        tay_w[0].t    = '0;
        tay_w[0].q0   = '0;
    end

    assign sdv_w[0] = sdv0_reg;
    assign ddv_w[0] = ddv0_reg;

    for (genvar i = 0; i < LOG_STEPS; i++)
    begin : g_log
        bsl_log_cell u_num (.clk(clk), .en(adv), .d_in(lgn_w[i]), .d_out(lgn_w[i+1]));
        bsl_log_cell u_den (.clk(clk), .en(adv), .d_in(lgd_w[i]), .d_out(lgd_w[i+1]));
    end

    for (genvar j = 0; j < TAY_TERMS; j++)
    begin : g_tay
        bsl_tay_cell u_term (
            .clk   (clk),
            .en    (adv),
            .n     (5'(j + 1)),
            .d_in  (tay_w[j]),
            .d_out (tay_w[j+1])
        );
    end

    for (genvar s = 0; s < SDIV_STEPS; s++)
    begin : g_sdiv
        bsl_div_cell u_step (.clk(clk), .en(adv), .d_in(sdv_w[s]), .d_out(sdv_w[s+1]));
    end

    for (genvar d = 0; d < DDIV_STEPS; d++)
    begin : g_ddiv
        bsl_div_cell u_step (.clk(clk), .en(adv), .d_in(ddv_w[d]), .d_out(ddv_w[d+1]));
    end

    // ---------------- tails ----------------
    always_comb
    begin
        // logit: log2 difference, times ln2, round half up in magnitude
        ldiff = $signed({1'b0, lgn_w[LOG_STEPS].ip, lgn_w[LOG_STEPS].frac})
              - $signed({1'b0, lgd_w[LOG_STEPS].ip, lgd_w[LOG_STEPS].frac});
        lmag  = ldiff[37] ? 38'(-ldiff) : 38'(ldiff);
        lrs   = {1'b0, lt_reg} + LG_RND;
        lr    = 32'(lrs >> LG_SHIFT);

        // sigmoid: e^-a = sum >> k, then 2^62 / (2^32 + e^-a) seeded for long division
        sum_u = tay_w[TAY_TERMS].sum[32:0];
        ex    = (tay_w[TAY_TERMS].k >= 7'd63) ? 33'd0 : (sum_u >> tay_w[TAY_TERMS].k);
        sden  = 34'h1_0000_0000 + {1'b0, ex};
        shd   = sden[33:1];
        sq    = sdv_w[SDIV_STEPS].q[30:0];
        sdmp  = {1'b0, sprod_reg} + 63'h2000_0000;
        if (w33[32])
            sres = $signed({{4{range_min_reg[31]}}, range_min_reg})
                 - $signed({3'd0, sdmp[62:30]});
        else
            sres = $signed({{4{range_min_reg[31]}}, range_min_reg})
                 + $signed({3'd0, sdmp[62:30]});

        // derivative: saturate the rounded quotient
        dq   = ddv_w[DDIV_STEPS].q;
        dbig = drv_big_reg[ST_DDIV_END];
        if (ctl_reg[ST_DDIV_END].drv_neg)
        begin
            if (dbig || (dq > 32'h8000_0000))
                drv_val = 32'sh8000_0000;
            else
                drv_val = -$signed(dq);
        end
        else
        begin
            if (dbig || dq[31])
                drv_val = 32'sh7FFF_FFFF;
            else
                drv_val = $signed(dq);
        end
    end

    // ---------------- result select ----------------
    always_comb
    begin
        ce               = ctl_reg[ST_LAST];
        out_value_next   = '0;
        range_error_next = 1'b0;
        case (ce.kind)
            KIND_LOGIT:
            begin
                if (ce.lgt_err)
                    range_error_next = 1'b1;
                else if (ce.lgt_lo)
                    out_value_next = LIM_NEG;
                else if (ce.lgt_hi)
                    out_value_next = LIM_POS;
                else
                    out_value_next = lgt_val_reg[ST_LAST];
            end
            KIND_SIGMOID:
            begin
                out_value_next = sig_val_reg;
            end
            KIND_DERIV:
            begin
                if (ce.drv_err)
                    range_error_next = 1'b1;
                else
                    out_value_next = drv_val_reg[ST_LAST];
            end
            default:
            begin
                range_error_next = 1'b1;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= '0;
            range_max_reg <= RANGE_MAX_RST;
            out_valid_reg <= 1'b0;
            for (int i = ST_PREP; i <= ST_LAST; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_RANGE_MIN: range_min_reg <= cfg.data;
                    CFG_RANGE_MAX: range_max_reg <= cfg.data;
                    default:       ;
                endcase
            end
            if (adv)
            begin
                out_valid_reg    <= ctl_reg[ST_LAST].valid;
                ctl_reg[ST_PREP] <= ctl_in;
                for (int i = ST_PREP + 1; i <= ST_LAST; i++)
                begin
                    ctl_reg[i] <= ctl_reg[i-1];
                end
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            nm_reg <= nabs[31:0];
            dm_reg <= dabs[31:0];
            a_reg  <= yabs[A_W-1:0];

            // stage 2
            lgn0_reg.m    <= nm_reg << (5'd31 - pn);
            lgn0_reg.frac <= '0;
            lgn0_reg.ip   <= pn;
            lgd0_reg.m    <= dm_reg << (5'd31 - pd);
            lgd0_reg.frac <= '0;
            lgd0_reg.ip   <= pd;
            dprod_reg     <= nm_reg * dm_reg;
            k2_reg        <= za[FRAC_BITS+Z_W-1 -: K_W];
            f_reg         <= za[FRAC_BITS +: 32];

            // stage 3
            g_reg         <= gp[63:32];
            k3_reg        <= k2_reg;
            ddv0_reg.rem  <= {2'd0, dsum[63:32]};
            ddv0_reg.dvs  <= {2'd0, w32};
            ddv0_reg.low  <= dsum[31:0];
            ddv0_reg.q    <= '0;
            drv_big_reg[ST_G] <= dsum[63:32] >= w32;
            for (int i = ST_G + 1; i <= ST_DDIV_END; i++)
            begin
                drv_big_reg[i] <= drv_big_reg[i-1];
            end

            // logit tail
            lmag_reg  <= lmag[36:6];
            lneg_reg  <= ldiff[37];
            lt_reg    <= lmag_reg * LN2_Q32;
            lneg2_reg <= lneg_reg;
            lgt_val_reg[ST_LG_RES] <= lneg2_reg ? -$signed(lr) : $signed(lr);
            for (int i = ST_LG_RES + 1; i <= ST_LAST; i++)
            begin
                lgt_val_reg[i] <= lgt_val_reg[i-1];
            end

            // sigmoid tail
            sdv0_reg.rem <= {2'd0, 32'h8000_0000 + {30'd0, shd[32:31]}};
            sdv0_reg.dvs <= sden;
            sdv0_reg.low <= {shd[30:0], 1'b0};
            sdv0_reg.q   <= '0;
            sadj_reg     <= ctl_reg[ST_SDIV_END].sig_neg ? 31'h4000_0000 - sq : sq;
            sprod_reg    <= wmag * sadj_reg;
            if (sres > 36'sh0_7FFF_FFFF)
                sig_val_reg <= 32'sh7FFF_FFFF;
            else if (sres < -36'sh0_8000_0000)
                sig_val_reg <= 32'sh8000_0000;
            else
                sig_val_reg <= sres[31:0];

            // derivative tail
            drv_val_reg[ST_DRV_RES] <= drv_val;
            for (int i = ST_DRV_RES + 1; i <= ST_LAST; i++)
            begin
                drv_val_reg[i] <= drv_val_reg[i-1];
            end

            // result word
            out_value_reg   <= out_value_next;
            range_error_reg <= range_error_next;
        end
    end

endmodule
